// ===== rtl/core/fkxc_pkg.sv =====
// shared types, constants and the fnv multiply for the keystream xor cipher
package fkxc_pkg;

  // stream offset width and derived block index width
  localparam int OFFSET_BITS = 24;
  localparam int IDX_W       = OFFSET_BITS - 3;

  // fnv-1a 64-bit constants
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] KEY_RESET = FNV_BASIS;

  // round sequencer steps: 0..7 block bytes, 8 index tag, 9 final prime multiply
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_TAG  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(9);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_BUILD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow;
  } out_item_t;

  // multiply by the fnv prime modulo 2^64: small constant product plus a 40-bit shift
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [63:0] lo;
    lo = 64'(x * 64'h1b3);
    return lo + (x << 40);
  endfunction

endpackage

// ===== rtl/core/fnv_keystream_xor_cipher.sv =====
// keystream xor cipher top level: fnv-1a block builder with a cached block and sequencer
// a request goes from check straight to emit when the cached block matches the byte's block,
// the stream has overflowed or k = 0; otherwise k rounds build block index k = offset/8 first.
// the shared fnv prime multiplier does one step a cycle, 10 steps per round, k rounds.
// one request is in work at a time; in_ready is low while a block is being built.
// synchronous reset clears offset, cache valid and limit flag and loads the key basis.
module fnv_keystream_xor_cipher (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         cfg_key_hash,
  input  logic                in_valid,
  output logic                in_ready,
  input  fkxc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fkxc_pkg::out_item_t out_data
);
  import fkxc_pkg::*;

  state_t state, state_next;

  logic [63:0]            key_hash;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [63:0]            cached_block;
  logic [IDX_W-1:0]       cached_index;
  logic                   block_ready;
  logic                   limit_hit;

  logic [7:0]             data_byte;
  logic [63:0]            blk;
  logic [63:0]            h;
  logic [STEP_W-1:0]      step;
  logic [IDX_W-1:0]       rounds_left;

  logic [IDX_W-1:0]       blk_index;
  logic                   cache_hit;
  logic [63:0]            mul_operand;
  logic [63:0]            mul_result;
  logic                   accept;
  logic                   emit_fire;
  logic                   build_start;
  logic                   build_done;
  logic                   zero_block;

  // block index of the current offset and cache lookup
  assign blk_index = byte_offset[OFFSET_BITS-1:3];
  assign cache_hit = block_ready && (cached_index == blk_index);

  // shared multiplier operand select
  always_comb begin
    if (step < STEP_TAG) begin
      mul_operand = h ^ {56'd0, blk[8*step[2:0] +: 8]};
    end else if (step == STEP_TAG) begin
      mul_operand = h ^ {56'd0, 8'(blk_index)};
    end else begin
      mul_operand = h;
    end
  end
  assign mul_result = fnv_mul(mul_operand);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (limit_hit || cache_hit || (blk_index == '0)) state_next = S_EMIT;
        else state_next = S_BUILD;
      end
      S_BUILD: begin
        if (step == STEP_LAST && rounds_left == IDX_W'(1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    emit_fire   = 1'b0;
    build_start = 1'b0;
    build_done  = 1'b0;
    zero_block  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CHECK: begin
        if (!limit_hit && !cache_hit) begin
          if (blk_index == '0) zero_block = 1'b1;
          else build_start = 1'b1;
        end
      end
      S_BUILD: begin
        build_done = (step == STEP_LAST) && (rounds_left == IDX_W'(1));
      end
      S_EMIT: begin
        emit_fire = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stream control state, key register and cache
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hash     <= KEY_RESET;
      byte_offset  <= '0;
      cached_block <= '0;
      cached_index <= '0;
      block_ready  <= 1'b0;
      limit_hit    <= 1'b0;
    end else begin
      if (accept && in_data.restart) begin
        byte_offset <= '0;
        block_ready <= 1'b0;
        limit_hit   <= 1'b0;
      end
      if (zero_block) begin
        cached_block <= key_hash;
        cached_index <= blk_index;
        block_ready  <= 1'b1;
      end
      if (build_done) begin
        cached_block <= mul_result;
        cached_index <= blk_index;
        block_ready  <= 1'b1;
      end
      if (emit_fire && !limit_hit) begin
        if (byte_offset == '1) limit_hit <= 1'b1;
        else byte_offset <= byte_offset + OFFSET_BITS'(1);
      end
      if (cfg_valid && cfg_ready) begin
        key_hash    <= cfg_key_hash;
        block_ready <= 1'b0;
      end
    end
  end

  // request byte capture
  always_ff @(posedge clk) begin
    if (accept) data_byte <= in_data.data_byte;
  end

  // round datapath: one fnv step per cycle through the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      rounds_left <= '0;
    end else if (build_start) begin
      step        <= '0;
      rounds_left <= blk_index;
    end else if (state == S_BUILD) begin
      if (step == STEP_LAST) begin
        step        <= '0;
        rounds_left <= rounds_left - IDX_W'(1);
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build_start) begin
      blk <= key_hash;
      h   <= FNV_BASIS;
    end else if (state == S_BUILD) begin
      if (step == STEP_LAST) begin
        blk <= mul_result;
        h   <= FNV_BASIS;
      end else begin
        h <= mul_result;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (limit_hit) begin
        out_data.out_byte <= data_byte;
        out_data.overflow <= 1'b1;
      end else begin
        out_data.out_byte <= data_byte ^ cached_block[8*byte_offset[2:0] +: 8];
        out_data.overflow <= 1'b0;
      end
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("round step out of range");

  a_limit_at_end: assert property (@(posedge clk) disable iff (rst)
    limit_hit |-> (byte_offset == '1))
    else $error("limit flag set before last offset");

  a_build_caches: assert property (@(posedge clk) disable iff (rst)
    (build_done && !(cfg_valid && cfg_ready)) |=> (block_ready && state == S_EMIT))
    else $error("finished build did not fill cache");

  a_emit_has_block: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !limit_hit) |-> cache_hit)
    else $error("result emitted without matching cached block");

  a_overflow_pass: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && limit_hit) |=>
      (out_data.overflow && out_data.out_byte == $past(data_byte)))
    else $error("overflowed byte not passed through");

endmodule

// ===== dv/fnv_keystream_xor_cipher_tb.sv =====
// self-checking testbench for the fnv keystream xor cipher: directed and random byte streams
module fnv_keystream_xor_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fkxc_pkg::*;

  // receiver stall modes
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  localparam logic [63:0] KEY_TOP_BIT = 64'h8000_0000_0000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_key_hash = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  // stimulus knobs shared by the test tasks
  int rx_mode = RX_FREE;
  int gap_max = 0;
  int burst_left = 0;
  int hold_asked = 0;
  int err_cnt = 0;

  // predicted cipher state
  logic [63:0]            pred_key = KEY_RESET;
  logic [OFFSET_BITS-1:0] pred_offset = '0;
  logic [63:0]            pred_block = '0;
  logic [IDX_W-1:0]       pred_block_idx = '0;
  logic                   pred_block_ok = 1'b0;
  logic                   pred_overflowed = 1'b0;

  out_item_t expected_bytes_q[$];

  fnv_keystream_xor_cipher dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_key_hash (cfg_key_hash),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // keystream block idx: idx rounds of fnv-1a over the block bytes, index tag, extra prime
  function automatic logic [63:0] expand_block(input logic [63:0] seed,
                                               input logic [IDX_W-1:0] idx);
    logic [63:0] blk;
    logic [63:0] h;
    logic [7:0]  tag;
    blk = seed;
    tag = idx[7:0];
    for (int unsigned r = 0; r < idx; r++) begin
      h = FNV_BASIS;
      for (int ln = 0; ln < 8; ln++) begin
        h = (h ^ {56'd0, blk[8*ln +: 8]}) * FNV_PRIME;
      end
      h = (h ^ {56'd0, tag}) * FNV_PRIME;
      blk = h * FNV_PRIME;
    end
    return blk;
  endfunction

  // expected result of one accepted request, advancing the predicted stream
  function automatic out_item_t cipher_byte(input in_item_t it);
    out_item_t        res;
    logic [IDX_W-1:0] idx;
    if (it.restart) begin
      pred_offset     = '0;
      pred_block_ok   = 1'b0;
      pred_overflowed = 1'b0;
    end
    if (pred_overflowed) begin
      res.out_byte = it.data_byte;
      res.overflow = 1'b1;
      return res;
    end
    idx = pred_offset[OFFSET_BITS-1:3];
    if (!pred_block_ok || pred_block_idx != idx) begin
      pred_block_idx = idx;
      pred_block     = expand_block(pred_key, idx);
      pred_block_ok  = 1'b1;
    end
    res.out_byte = it.data_byte ^ pred_block[8*pred_offset[2:0] +: 8];
    res.overflow = 1'b0;
    // the last offset sets the overflow flag instead of wrapping
    if (&pred_offset) pred_overflowed = 1'b1;
    else pred_offset = pred_offset + OFFSET_BITS'(1);
    return res;
  endfunction

  // send one request, with random gaps between bursts
  task automatic push_byte(input logic [7:0] b, input logic rs);
    int        gap;
    in_item_t  it;
    out_item_t exp_item;
    if (burst_left == 0) begin
      burst_left = (gap_max == 0) ? 64 : $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.data_byte = b;
    it.restart   = rs;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    exp_item = cipher_byte(it);
    expected_bytes_q = {expected_bytes_q, exp_item};
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // key write, only with the block idle
  task automatic write_key(input logic [63:0] key);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_key_hash <= key;
    do @(posedge clk); while (!cfg_ready);
    pred_key      = key;
    pred_block_ok = 1'b0;
    cfg_valid    <= 1'b0;
  endtask

  task automatic send_stream(input int len, input bit fresh);
    logic rs;
    for (int i = 0; i < len; i++) begin
      rs = (i == 0 && fresh) || ($urandom_range(0, 63) == 0);
      push_byte(8'($urandom_range(0, 255)), rs);
    end
  endtask

  // bytes from reset with the reset key: field extremes, block crossing, restarts
  task automatic test_first_bytes();
    rx_mode = RX_FREE;
    gap_max = 0;
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h5a, 1'b0);
    for (int i = 0; i < 6; i++) push_byte(8'(1 << i), 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
  endtask

  // key change in the middle of a stream keeps the offset and rebuilds the block
  task automatic test_key_mid_stream();
    rx_mode = RX_LIGHT;
    gap_max = 3;
    for (int i = 0; i < 5; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    write_key({$urandom, $urandom});
    for (int i = 0; i < 4; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // one long stream reaching deep block indexes, with a full drain halfway
  task automatic test_long_stream();
    rx_mode = RX_LIGHT;
    gap_max = 6;
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    for (int i = 1; i < 320; i++) begin
      if (i == 160) wait_drained();
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    rx_mode = RX_HEAVY;
    gap_max = 0;
    send_stream(10, 1'b1);
    hold_asked++;
    send_stream(30, 1'b0);
    rx_mode = RX_LIGHT;
  endtask

  // random streams under several keys, extremes included
  task automatic test_random_streams();
    logic [63:0] keys[5];
    int          sent;
    int          len;
    keys[0] = 64'h0;
    keys[1] = '1;
    keys[2] = KEY_TOP_BIT | {$urandom, $urandom};
    keys[3] = {$urandom, $urandom};
    keys[4] = KEY_RESET;
    foreach (keys[k]) begin
      write_key(keys[k]);
      rx_mode = $urandom_range(RX_FREE, RX_HEAVY);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      sent = 0;
      while (sent < 50) begin
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
        send_stream(len, $urandom_range(0, 4) != 0);
        sent += len;
      end
    end
  endtask

  // receiver: random ready pattern, free running stretches, long hold-offs on request
  initial begin
    int          hold_seen;
    int          hold_left;
    logic [31:0] ready_pat;
    int          pat_left;
    hold_seen = 0;
    hold_left = 0;
    ready_pat = '0;
    pat_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = $urandom_range(48, 96);
      end
      if (pat_left == 0) begin
        ready_pat = $urandom;
        pat_left  = 16;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_mode == RX_FREE) begin
        out_ready <= 1'b1;
      end else if (rx_mode == RX_LIGHT) begin
        out_ready <= ready_pat[0] | ready_pat[1];
      end else begin
        out_ready <= ready_pat[0] & ready_pat[1];
      end
      ready_pat = ready_pat >> 2;
      pat_left--;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result out_byte=%02h overflow=%0b",
                 $realtime, out_data.out_byte, out_data.overflow);
      end else begin
        exp_item = expected_bytes_q.pop_front();
        if (out_data.out_byte !== exp_item.out_byte) begin
          err_cnt++;
          $display("%0t: out_byte mismatch expected %02h actual %02h",
                   $realtime, exp_item.out_byte, out_data.out_byte);
        end
        if (out_data.overflow !== exp_item.overflow) begin
          err_cnt++;
          $display("%0t: overflow mismatch expected %0b actual %0b",
                   $realtime, exp_item.overflow, out_data.overflow);
        end
      end
    end
  end

  // the offset limit needs 2^24 bytes in one stream, out of reach here;
  // overflow is still predicted and is checked to stay low
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_first_bytes();
    test_key_mid_stream();
    test_long_stream();
    test_backpressure();
    test_random_streams();
    wait_drained();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== fnv_keystream_xor_cipher.f =====
rtl/core/fkxc_pkg.sv
rtl/core/fnv_keystream_xor_cipher.sv
dv/fnv_keystream_xor_cipher_tb.sv
